FILE: sv/ptpd_pkg.sv
// shared types, constants and helpers for the point transform block
`timescale 1ns / 1ps

package ptpd_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 64;
    localparam int COORD_W       = 32;
    localparam int PROD_W        = 64;
    localparam int SUM_W         = 66;
    localparam int MAG_W         = 64;
    localparam int REM_W         = 96;
    localparam int QUO_W         = 32;
    localparam int MAC_STAGES    = 3;
    localparam int DIV_STAGES    = QUO_W + 3;
    localparam int LATENCY       = MAC_STAGES + DIV_STAGES;

    localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_regs_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam cfg_regs_t CFG_RESET = {
        64'h0001_0000_0000_0000, 64'h0, 64'h0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0001_0000
    };

    typedef struct packed {
        logic ovf;
        logic neg;
        logic nzero;
        logic wzero;
        logic nneg;
    } lane_flags_t;

    function automatic logic signed [COORD_W-1:0] mat_entry(
        input cfg_regs_t regs, input int r, input int c);
        logic [CFG_W-1:0] v;
        v = regs[r * 2 + c / 2];
        return (c % 2 == 1) ? $signed(v[63:32]) : $signed(v[31:0]);
    endfunction

endpackage

FILE: sv/point_transform_perspective_divide_top.sv
// top level: config registers, matrix stage, three divide lanes, valid pipeline
//
// usage
//   s_ channel takes one point per beat: s_tdata = pos_x, pos_y, pos_z
//   (32-bit signed fixed point each, pos_x lowest).
//   m_ channel gives one result per point in order: m_tdata = out_x, out_y,
//   out_z; m_tuser = w_zero, set when w was zero and each output saturated or zero.
//   the matrix sits in eight 64-bit registers written through cfg_we,
//   cfg_addr and cfg_wdata; write them only while no beat is in flight.
// pipeline and throughput
//   an accepted input beat passes the multiply and sum stages, then the
//   divide lanes (sign split, overflow test, one quotient bit per stage
//   over 32 stages, and saturation into the output register) before its
//   output beat. one beat per cycle while the output side is not stalled.
// reset and stall
//   aresetn low empties the pipeline and loads the identity matrix.
//   when m_tready is low with m_tvalid high the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module point_transform_perspective_divide_top import ptpd_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [95:0]          s_tdata,   // pos_x, pos_y, pos_z
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata,   // out_x, out_y, out_z
    output logic [0:0]           m_tuser,   // w_zero
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_regs_t           cfg_reg;
    logic [LATENCY-1:0]  vld_reg, vld_next;
    logic                en;
    sum_t                sum [4];
    logic [COORD_W-1:0]  quo [3];
    logic                wz;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[LATENCY-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    ptpd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk  (aclk),
        .en    (en),
        .pos_x (s_tdata[31:0]),
        .pos_y (s_tdata[63:32]),
        .pos_z (s_tdata[95:64]),
        .mat   (cfg_reg),
        .sum   (sum)
    );

    ptpd_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .aclk (aclk), .en (en), .num (sum[0]), .den (sum[3]), .quo (quo[0]), .wz (wz)
    );

    ptpd_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .aclk (aclk), .en (en), .num (sum[1]), .den (sum[3]), .quo (quo[1]), .wz ()
    );

    ptpd_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .aclk (aclk), .en (en), .num (sum[2]), .den (sum[3]), .quo (quo[2]), .wz ()
    );

    assign m_tvalid = vld_reg[LATENCY-1];
    assign m_tdata  = {quo[2], quo[1], quo[0]};
    assign m_tuser  = wz;

endmodule

FILE: sv/ptpd_mac.sv
// point times 4x4 matrix, three register stages, exact signed column sums
`timescale 1ns / 1ps

module ptpd_mac import ptpd_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] pos_z,
    input  cfg_regs_t                 mat,
    output sum_t                      sum [4]
);

    logic signed [PROD_W-1:0]  prod_reg [3][4];
    logic signed [COORD_W-1:0] tr_reg [4];
    sum_t                      pa_reg [4];
    sum_t                      pb_reg [4];
    sum_t                      sum_reg [4];
    logic signed [COORD_W-1:0] pos [3];

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 3; r++) begin
                    prod_reg[r][c] <= pos[r] * mat_entry(mat, r, c);
                end
                tr_reg[c] <= mat_entry(mat, 3, c);
                pa_reg[c] <= SUM_W'(prod_reg[0][c]) + SUM_W'(prod_reg[1][c]);
                pb_reg[c] <= SUM_W'(prod_reg[2][c]) + (SUM_W'(tr_reg[c]) <<< FRAC_BITS);
                sum_reg[c] <= pa_reg[c] + pb_reg[c];
            end
        end
    end

    assign sum = sum_reg;

endmodule

FILE: sv/ptpd_div.sv
// one divide lane: sign split, overflow test, restoring stages, saturation
`timescale 1ns / 1ps

module ptpd_div import ptpd_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               en,
    input  sum_t               num,
    input  sum_t               den,
    output logic [COORD_W-1:0] quo,
    output logic               wz
);

    logic               a_nneg_reg, a_wneg_reg;
    logic [MAG_W-1:0]   a_nmag_reg, a_wmag_reg;
    sum_t               nabs, wabs;
    logic [REM_W-1:0]   r_reg [QUO_W+1];
    logic [QUO_W-1:0]   q_reg [QUO_W+1];
    logic [MAG_W-1:0]   wm_reg [QUO_W+1];
    lane_flags_t        fl_reg [QUO_W+1];
    logic [COORD_W-1:0] quo_reg, quo_next;
    logic               wz_reg;
    logic [REM_W-1:0]   b_dvd;
    lane_flags_t        b_fl;

    assign nabs = num[SUM_W-1] ? -num : num;
    assign wabs = den[SUM_W-1] ? -den : den;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_nneg_reg <= num[SUM_W-1];
            a_wneg_reg <= den[SUM_W-1];
            a_nmag_reg <= nabs[MAG_W-1:0];
            a_wmag_reg <= wabs[MAG_W-1:0];
        end
    end

    always_comb begin
        b_dvd       = REM_W'(a_nmag_reg) << FRAC_BITS;
        b_fl.ovf    = b_dvd >= {a_wmag_reg, {QUO_W{1'b0}}};
        b_fl.neg    = a_nneg_reg ^ a_wneg_reg;
        b_fl.nzero  = a_nmag_reg == '0;
        b_fl.wzero  = a_wmag_reg == '0;
        b_fl.nneg   = a_nneg_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]  <= b_dvd;
            q_reg[0]  <= '0;
            wm_reg[0] <= a_wmag_reg;
            fl_reg[0] <= b_fl;
        end
    end

    for (genvar i = 0; i < QUO_W; i++) begin : g_step
        localparam int K = QUO_W - 1 - i;
        logic [REM_W-1:0] ws;
        logic             ge;
        assign ws = REM_W'(wm_reg[i]) << K;
        assign ge = r_reg[i] >= ws;
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i+1]  <= ge ? r_reg[i] - ws : r_reg[i];
                q_reg[i+1]  <= q_reg[i] | (QUO_W'(ge) << K);
                wm_reg[i+1] <= wm_reg[i];
                fl_reg[i+1] <= fl_reg[i];
            end
        end
    end

    always_comb begin
        if (fl_reg[QUO_W].wzero) begin
            quo_next = fl_reg[QUO_W].nzero ? '0 : (fl_reg[QUO_W].nneg ? SAT_NEG : SAT_POS);
        end else if (fl_reg[QUO_W].neg) begin
            quo_next = (fl_reg[QUO_W].ovf || q_reg[QUO_W][QUO_W-1]) ? SAT_NEG
                                                                    : -q_reg[QUO_W];
        end else begin
            quo_next = (fl_reg[QUO_W].ovf || q_reg[QUO_W][QUO_W-1]) ? SAT_POS
                                                                    : q_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
            wz_reg  <= fl_reg[QUO_W].wzero;
        end
    end

    assign quo = quo_reg;
    assign wz  = wz_reg;

endmodule

FILE: sv/ptpd_checker.sv
// port-level checks for the point transform block
`timescale 1ns / 1ps

module ptpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat right after reset");

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output side");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_wzero_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[31:0] == 32'h0 || m_tdata[31:0] == 32'h7FFF_FFFF
             || m_tdata[31:0] == 32'h8000_0000)
            && (m_tdata[63:32] == 32'h0 || m_tdata[63:32] == 32'h7FFF_FFFF
             || m_tdata[63:32] == 32'h8000_0000)
            && (m_tdata[95:64] == 32'h0 || m_tdata[95:64] == 32'h7FFF_FFFF
             || m_tdata[95:64] == 32'h8000_0000))
        else $error("zero w beat not saturated");

endmodule

bind point_transform_perspective_divide_top ptpd_checker u_ptpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/tb.sv
// testbench for the point transform block: random points and matrices against a predictor
`timescale 1ns / 1ps

module tb;
    import ptpd_pkg::*;

    localparam int FB = 16;

    typedef struct packed {
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } point_t;

    typedef struct packed {
        logic        wz;
        logic [95:0] xyz;
    } proj_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    logic [63:0] mat_regs [NUM_REGS];
    point_t point_q[$];
    proj_t proj_q[$];
    int mismatches = 0;
    int beats_out = 0;
    int wzero_seen = 0;
    int sat_seen = 0;
    bit hold_sink = 1'b0;
    bit stream_done = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    point_transform_perspective_divide_top #(.FRAC_BITS(FB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    function automatic logic signed [31:0] entry(int r, int c);
        logic [63:0] v;
        v = mat_regs[r * 2 + c / 2];
        return (c % 2) ? v[63:32] : v[31:0];
    endfunction

    function automatic logic signed [127:0] col_sum(point_t p, int c);
        logic signed [127:0] s;
        s = $signed(p.x) * 128'(entry(0, c)) + $signed(p.y) * 128'(entry(1, c))
            + $signed(p.z) * 128'(entry(2, c));
        s = s + (128'(entry(3, c)) <<< FB);
        return s;
    endfunction

    function automatic proj_t project(point_t p);
        proj_t r;
        logic signed [127:0] w, n, q;
        logic [31:0] o;
        w = col_sum(p, 3);
        r.wz = (w == 0);
        for (int c = 0; c < 3; c++) begin
            n = col_sum(p, c);
            if (w == 0) begin
                o = (n == 0) ? 32'h0 : (n < 0 ? SAT_NEG : SAT_POS);
            end else begin
                q = (n <<< FB) / w;
                if (q > 128'sh7FFF_FFFF) o = SAT_POS;
                else if (q < -128'sh8000_0000) o = SAT_NEG;
                else o = q[31:0];
            end
            r.xyz[c*32 +: 32] = o;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            1: return 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000) <<< 4;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (point_q.size() > 0 && $urandom_range(0, 3) != 0) begin
                    s_tdata <= point_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (s_tvalid && s_tready) proj_q.push_back(project(s_tdata));
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (proj_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h %b", m_tdata, m_tuser);
                end else begin
                    proj_t e;
                    e = proj_q.pop_front();
                    if (e.wz) wzero_seen++;
                    if (e.xyz[31:0] == SAT_POS || e.xyz[31:0] == SAT_NEG) sat_seen++;
                    for (int c = 0; c < 3; c++)
                        if (e.xyz[c*32 +: 32] !== m_tdata[c*32 +: 32]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("lane %0d: exp %h got %h", c,
                                    e.xyz[c*32 +: 32], m_tdata[c*32 +: 32]);
                        end
                    if (e.wz !== m_tuser[0]) begin
                        mismatches++;
                        if (mismatches <= 10) $display("w_zero: exp %b got %b", e.wz, m_tuser);
                    end
                end
            end
            m_tready <= hold_sink ? 1'b0 :
                ($urandom_range(0, 9) == 0 ? 1'b0 : ($urandom_range(0, 3) != 0));
        end
    end

    task automatic wait_drained();
        while (point_q.size() > 0 || s_tvalid || proj_q.size() > 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_reg(int idx, logic [63:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx[CFG_IDX_W-1:0];
        cfg_wdata <= v;
        mat_regs[idx] = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_matrix(int mode);
        for (int i = 0; i < NUM_REGS; i++) begin
            logic [63:0] v;
            case (mode)
                0: v = {$urandom, $urandom};
                1: v = {32'h7FFF_FFFF, 32'h8000_0000};
                2: v = 64'h0;
                default: v = {16'($urandom_range(0, 3) - 1), 16'($urandom),
                              16'($urandom_range(0, 3) - 1), 16'($urandom)};
            endcase
            write_reg(i, v);
        end
    endtask

    task automatic burst(int n, int mode);
        point_t p;
        for (int i = 0; i < n; i++) begin
            p.x = rand_coord();
            p.y = rand_coord();
            p.z = rand_coord();
            if (mode == 1) begin
                p.x = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
                p.y = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
                p.z = 32'h0;
            end
            point_q.push_back(p);
        end
    endtask

    initial begin
        point_t p;
        for (int i = 0; i < NUM_REGS; i++) mat_regs[i] = CFG_RESET[i];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // identity: extremes and zero
        p = '0;
        point_q.push_back(p);
        point_q.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        point_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        point_q.push_back({32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000});
        wait_drained();
        // w = z: zero w, sign of numerator, saturation
        write_reg(6, 64'h0);
        write_reg(7, 64'h0);
        write_reg(5, {32'h0001_0000, 32'h0001_0000});
        point_q.push_back({32'h0, 32'h0001_0000, 32'hFFFF_0000});
        point_q.push_back({32'h0, 32'h0, 32'h0});
        point_q.push_back({32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000});
        point_q.push_back({32'hFFFF_FFFF, 32'h0002_0000, 32'h0});
        point_q.push_back({32'h0001_0000, 32'h0, 32'h0});
        wait_drained();
        load_matrix(1);
        burst(10, 0);
        wait_drained();
        load_matrix(2);
        burst(5, 0);
        wait_drained();
        // long receiver hold while points keep coming
        load_matrix(3);
        hold_sink = 1'b1;
        burst(100, 0);
        repeat (300) @(posedge aclk);
        hold_sink = 1'b0;
        wait_drained();
        for (int ph = 0; ph < 8; ph++) begin
            load_matrix(ph % 2 ? 3 : 0);
            burst(100, ph % 3 == 2 ? 1 : 0);
            wait_drained();
        end
        $display("%0d results checked over varied matrices, %0d with zero w, %0d saturated x",
                 beats_out, wzero_seen, sat_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: point_transform_perspective_divide_top.f
sv/ptpd_pkg.sv
sv/ptpd_mac.sv
sv/ptpd_div.sv
sv/point_transform_perspective_divide_top.sv
sv/ptpd_checker.sv
dv/tb.sv
